// ===== src/assert_macros.svh =====
// Assertion macros shared by the checker module of the block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// An implication in the same cycle, sampled on aclk and off during reset.
`define ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("bpd3 checker: same-cycle implication failed");

// An implication that must hold in the following cycle.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("bpd3 checker: next-cycle implication failed");

`endif

// ===== src/bpd3_pkg.sv =====
// Types, constants and the pattern table of the block pattern dither.
`default_nettype none

package bpd3_pkg;

    localparam int TILE_SIDE   = 3;
    localparam int CFG_W       = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int COORD_W     = 14;
    localparam int OUT_COORD_W = 12;
    localparam int SUM_W       = 12;
    localparam int COUNT_W     = 4;
    localparam int EXT_W       = 2;
    localparam int LEVEL_W     = 4;
    localparam int MASK_W      = 9;
    localparam int DIV_STEPS   = 12;
    localparam int DIV_CNT_W   = 4;
    localparam int TOP_LEVEL   = 9;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_SET = 2'd2;

    localparam logic [CFG_W-1:0] ROWS_RESET = 13'd480;
    localparam logic [CFG_W-1:0] COLS_RESET = 13'd640;

    localparam logic [15:0] LUMA_COEF_R = 16'd19595;
    localparam logic [15:0] LUMA_COEF_G = 16'd38470;
    localparam logic [15:0] LUMA_COEF_B = 16'd7471;
    localparam logic [23:0] LUMA_ROUND  = 24'd32768;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [OUT_COORD_W-1:0] pixel_row;
        logic [OUT_COORD_W-1:0] pixel_col;
        logic                   white;
        logic                   tile_done;
    } result_t;

    typedef struct packed {
        logic take;
        logic div_step;
        logic out_load;
        logic tile_adv;
    } cmd_t;

    typedef struct packed {
        logic last_pixel;
        logic div_done;
        logic out_free;
        logic out_last;
    } status_t;

    // Bit k of each mask is the colour of tile position k, row-major; 1 is white.
    localparam logic [MASK_W-1:0] PATTERN_MASKS [2][TOP_LEVEL+1] = '{
        '{9'h000, 9'h010, 9'h090, 9'h098, 9'h0D8, 9'h0F8, 9'h0FA, 9'h0FB, 9'h0FF, 9'h1FF},
        '{9'h000, 9'h001, 9'h081, 9'h0A1, 9'h0A5, 9'h0AD, 9'h0ED, 9'h0EF, 9'h0FF, 9'h1FF}
    };

    function automatic logic [MASK_W-1:0] pattern_mask(input logic set,
                                                       input logic [LEVEL_W-1:0] level);
        logic [MASK_W-1:0] mask;
        if (level > LEVEL_W'(TOP_LEVEL)) begin
            mask = PATTERN_MASKS[set][TOP_LEVEL];
        end else begin
            mask = PATTERN_MASKS[set][level];
        end
        return mask;
    endfunction

endpackage

`default_nettype wire

// ===== src/bpd3_ctrl.sv =====
// Controller state machine that sequences pixel intake, division and result output.
`default_nettype none

module bpd3_ctrl
    import bpd3_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    typedef enum logic [1:0] {
        ST_PIXEL,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg;

    always_comb begin
        cmd          = '0;
        state_next   = state_reg;
        cmd.take     = s_ready_reg && s_valid;
        cmd.div_step = (state_reg == ST_DIVIDE);
        cmd.out_load = (state_reg == ST_EMIT) && status.out_free;
        cmd.tile_adv = cmd.out_load && status.out_last;
        case (state_reg)
            ST_PIXEL: begin
                if (cmd.take && status.last_pixel) begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (status.div_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (cmd.tile_adv) begin
                    state_next = ST_PIXEL;
                end
            end
            default: begin
                state_next = ST_PIXEL;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_PIXEL;
            s_ready_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= (state_next == ST_PIXEL);
        end
    end

    assign s_ready = s_ready_reg;

endmodule

`default_nettype wire

// ===== src/bpd3_datapath.sv =====
// Datapath with configuration, tile tracking, luma sum, serial divider and result register.
`default_nettype none

module bpd3_datapath
    import bpd3_pkg::*;
#(
    parameter int MAX_DIM    = 4096,
    parameter int LEVEL_STEP = 25
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    input  wire pixel_t               s_data,
    input  wire cmd_t                 cmd,
    output status_t                   status,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output result_t                   m_data
);

    localparam int CFG_MAX = (1 << CFG_W) - 1;
    localparam logic [CFG_W-1:0] DIM_LIMIT =
        (MAX_DIM > CFG_MAX) ? CFG_W'(CFG_MAX) : CFG_W'(MAX_DIM);

    logic [CFG_W-1:0]     rows_reg, cols_reg;
    logic                 pset_reg;
    logic [COORD_W-1:0]   tile_top_reg, tile_left_reg;
    logic [EXT_W-1:0]     inner_row_reg, inner_col_reg;
    logic [SUM_W-1:0]     luma_sum_reg;
    logic [COUNT_W-1:0]   pixel_count_reg;
    logic [COUNT_W-1:0]   div_rem_reg, div_dsr_reg;
    logic [SUM_W-1:0]     div_dvd_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [EXT_W-1:0]     tile_h_reg, tile_w_reg;
    logic [EXT_W-1:0]     out_pr_reg, out_pc_reg;
    logic                 m_valid_reg;
    result_t              m_data_reg;

    logic [CFG_W-1:0]     rows_eff, cols_eff;
    logic [EXT_W-1:0]     tile_h, tile_w;
    logic [23:0]          luma_acc;
    logic [7:0]           luma;
    logic [SUM_W-1:0]     luma_sum_next;
    logic [COUNT_W-1:0]   pixel_count_next;
    logic                 col_more, row_more;
    logic [COUNT_W:0]     div_trial;
    logic                 div_bit;
    logic [LEVEL_W-1:0]   level;
    logic [MASK_W-1:0]    mask;
    logic [3:0]           mask_pos;
    logic [COORD_W-1:0]   left_step, top_step;
    result_t              result_next;

    function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] d;
        if (v == '0) begin
            d = CFG_W'(1);
        end else if (v > DIM_LIMIT) begin
            d = DIM_LIMIT;
        end else begin
            d = v;
        end
        return d;
    endfunction

    function automatic logic [EXT_W-1:0] tile_extent(input logic [COORD_W-1:0] start,
                                                     input logic [CFG_W-1:0] dim);
        logic [COORD_W-1:0] left;
        logic [EXT_W-1:0]   ext;
        left = COORD_W'(dim) - start;
        if (start >= COORD_W'(dim)) begin
            ext = EXT_W'(1);
        end else if (left < COORD_W'(TILE_SIDE)) begin
            ext = left[EXT_W-1:0];
        end else begin
            ext = EXT_W'(TILE_SIDE);
        end
        return ext;
    endfunction

    always_comb begin
        rows_eff = eff_dim(rows_reg);
        cols_eff = eff_dim(cols_reg);
        tile_h   = tile_extent(tile_top_reg, rows_eff);
        tile_w   = tile_extent(tile_left_reg, cols_eff);

        luma_acc = 24'(LUMA_COEF_R * 24'(s_data.red))
                 + 24'(LUMA_COEF_G * 24'(s_data.green))
                 + 24'(LUMA_COEF_B * 24'(s_data.blue))
                 + LUMA_ROUND;
        luma     = luma_acc[23:16];

        luma_sum_next    = luma_sum_reg + SUM_W'(luma);
        pixel_count_next = pixel_count_reg + COUNT_W'(1);

        col_more = ({1'b0, inner_col_reg} + 3'd1) < {1'b0, tile_w};
        row_more = ({1'b0, inner_row_reg} + 3'd1) < {1'b0, tile_h};

        div_trial = {div_rem_reg, div_dvd_reg[SUM_W-1]};
        div_bit   = (div_trial >= {1'b0, div_dsr_reg});

        // The level is ceil(avg / step) clamped to the top: count the thresholds passed.
        level = '0;
        for (int k = 1; k <= TOP_LEVEL; k++) begin
            if (32'(div_dvd_reg) > 32'((k - 1) * LEVEL_STEP)) begin
                level = level + LEVEL_W'(1);
            end
        end
        mask     = pattern_mask(pset_reg, level);
        mask_pos = {1'b0, out_pr_reg, 1'b0} + 4'(out_pr_reg) + 4'(out_pc_reg);

        left_step = tile_left_reg + COORD_W'(TILE_SIDE);
        top_step  = tile_top_reg + COORD_W'(TILE_SIDE);

        status.last_pixel = !col_more && !row_more;
        status.div_done   = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
        status.out_free   = !m_valid_reg || m_ready;
        status.out_last   = (out_pc_reg == tile_w_reg) ? 1'b0 :
                            (({1'b0, out_pc_reg} + 3'd1) == {1'b0, tile_w_reg})
                            && (({1'b0, out_pr_reg} + 3'd1) == {1'b0, tile_h_reg});

        result_next.pixel_row = OUT_COORD_W'(tile_top_reg + COORD_W'(out_pr_reg));
        result_next.pixel_col = OUT_COORD_W'(tile_left_reg + COORD_W'(out_pc_reg));
        result_next.white     = mask[mask_pos];
        result_next.tile_done = status.out_last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg        <= ROWS_RESET;
            cols_reg        <= COLS_RESET;
            pset_reg        <= 1'b0;
            tile_top_reg    <= '0;
            tile_left_reg   <= '0;
            inner_row_reg   <= '0;
            inner_col_reg   <= '0;
            luma_sum_reg    <= '0;
            pixel_count_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_IMAGE_ROWS:  rows_reg <= cfg_wdata;
                    REG_IMAGE_COLS:  cols_reg <= cfg_wdata;
                    REG_PATTERN_SET: pset_reg <= cfg_wdata[0];
                    default: begin
                    end
                endcase
            end

            if (cmd.take) begin
                if (col_more) begin
                    inner_col_reg   <= inner_col_reg + EXT_W'(1);
                    luma_sum_reg    <= luma_sum_next;
                    pixel_count_reg <= pixel_count_next;
                end else if (row_more) begin
                    inner_col_reg   <= '0;
                    inner_row_reg   <= inner_row_reg + EXT_W'(1);
                    luma_sum_reg    <= luma_sum_next;
                    pixel_count_reg <= pixel_count_next;
                end else begin
                    inner_col_reg   <= '0;
                    inner_row_reg   <= '0;
                    luma_sum_reg    <= '0;
                    pixel_count_reg <= '0;
                end
            end

            if (cmd.tile_adv) begin
                if (left_step >= COORD_W'(cols_eff)) begin
                    tile_left_reg <= '0;
                    if (top_step >= COORD_W'(rows_eff)) begin
                        tile_top_reg <= '0;
                    end else begin
                        tile_top_reg <= top_step;
                    end
                end else begin
                    tile_left_reg <= left_step;
                end
            end

            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take && status.last_pixel) begin
            div_dvd_reg <= luma_sum_next;
            div_dsr_reg <= pixel_count_next;
            div_rem_reg <= '0;
            div_cnt_reg <= '0;
            tile_h_reg  <= tile_h;
            tile_w_reg  <= tile_w;
            out_pr_reg  <= '0;
            out_pc_reg  <= '0;
        end else if (cmd.div_step) begin
            div_dvd_reg <= {div_dvd_reg[SUM_W-2:0], div_bit};
            div_rem_reg <= div_bit ? COUNT_W'(div_trial - {1'b0, div_dsr_reg})
                                   : div_trial[COUNT_W-1:0];
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
        end else if (cmd.out_load) begin
            if (({1'b0, out_pc_reg} + 3'd1) < {1'b0, tile_w_reg}) begin
                out_pc_reg <= out_pc_reg + EXT_W'(1);
            end else begin
                out_pc_reg <= '0;
                out_pr_reg <= out_pr_reg + EXT_W'(1);
            end
        end

        if (cmd.out_load) begin
            m_data_reg <= result_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// ===== src/block_pattern_dither_3x3.sv =====
// Top level of the 3x3 block pattern dither.
//
// Pixels enter on the s_ channel in block-scan order: 3x3 tiles in raster order,
// row-major inside a tile, with edge tiles cut short. Results leave on the m_ channel,
// one per tile pixel, row-major, with tile_done set on the last item of a tile.
// Inside a tile one pixel is taken per cycle while s_valid is high. The last pixel
// starts a restoring divider of the luma sum by the pixel count, one quotient bit
// a cycle. The results then leave one per cycle while m_ready is high, through a
// single output register. While results are emitted s_ready is low; once the last
// result of a tile is in the output register, pixels of the next tile are taken
// again. A stalled receiver holds the output register and so holds back the tile's
// output. Configuration is written on the cfg_ port at any edge with cfg_we high.
// Reset restores 480 rows, 640 columns and the first pattern set, and puts the
// tile position at the top-left corner.
`default_nettype none

module block_pattern_dither_3x3
    import bpd3_pkg::*;
#(
    parameter int MAX_DIM    = 4096,
    parameter int LEVEL_STEP = 25
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire pixel_t               s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output result_t                   m_data
);

    cmd_t    cmd;
    status_t status;

    bpd3_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    bpd3_datapath #(
        .MAX_DIM    (MAX_DIM),
        .LEVEL_STEP (LEVEL_STEP)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .cmd       (cmd),
        .status    (status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

// ===== src/bpd3_checker.sv =====
// Port-level checker for the block pattern dither and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"

module bpd3_checker
    import bpd3_pkg::*;
(
    input wire logic    aclk,
    input wire logic    aresetn,
    input wire logic    s_valid,
    input wire logic    s_ready,
    input wire logic    m_valid,
    input wire logic    m_ready,
    input wire result_t m_data
);

    // A stalled result holds its value.
    `ASSERT_NEXT(a_hold_stalled, m_valid && !m_ready, m_valid && $stable(m_data))

    // Results of a tile follow one another without a gap once taken.
    `ASSERT_NEXT(a_burst_no_gap, m_valid && m_ready && !m_data.tile_done, m_valid)

    // No pixel is taken while a tile's results are still being emitted.
    `ASSERT_IMPLY(a_no_intake_mid_tile, m_valid && !m_data.tile_done, !s_ready)

    // A fresh result only appears after intake has closed.
    `ASSERT_IMPLY(a_rise_after_intake_closed, $rose(m_valid), !$past(s_ready))

endmodule

bind block_pattern_dither_3x3 bpd3_checker u_checker (.*);

`default_nettype wire
